### rtl/core/dns_query_encoder_assert.svh
// ----------------------------------------------------------------------------
// dns query encoder assertion macros
// shorthand for clocked properties sampled on clk_i, quiet while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef DNS_QUERY_ENCODER_ASSERT_SVH
`define DNS_QUERY_ENCODER_ASSERT_SVH

// same-cycle implication
`define DQE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dqe assertion failed");

// next-cycle implication
`define DQE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dqe assertion failed");

`endif

### rtl/core/dqe_pkg.sv
// ----------------------------------------------------------------------------
// dqe_pkg
// shared constants, codes and control structs of the dns query encoder
// ----------------------------------------------------------------------------
package dqe_pkg;

  // sizes
  localparam int unsigned LABEL_MAX_DEF = 63;
  localparam int unsigned LENGTH_MAX    = 512;
  localparam int unsigned HDR_LEN       = 12;
  localparam int unsigned TAIL_LEN      = 5;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_TYPE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIMIT = 1'b1;
  localparam logic [15:0] QUERY_TYPE_RST = 16'd1;
  localparam logic [9:0]  SIZE_LIMIT_RST = 10'd300;

  // action codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_CHAR  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  // status codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_LONG  = 2'd2;
  localparam logic [1:0] ERR_SIZE  = 2'd3;

  // message bytes
  localparam logic [7:0] DOT_CHAR     = 8'h2e;
  localparam logic [7:0] FLAGS_RD     = 8'h01;
  localparam logic [7:0] QDCOUNT_LO   = 8'h01;
  localparam logic [7:0] CLASS_IN_LO  = 8'h01;

  // header byte positions
  localparam int unsigned POS_ID_HI   = 0;
  localparam int unsigned POS_ID_LO   = 1;
  localparam int unsigned POS_FLAGS   = 2;
  localparam int unsigned POS_QDCOUNT = 5;

  // tail byte positions, after the pending label
  localparam int unsigned TPOS_TYPE_HI = 1;
  localparam int unsigned TPOS_TYPE_LO = 2;
  localparam int unsigned TPOS_CLASS   = 4;

  typedef struct packed {
    logic accept;   // input item taken this cycle
    logic load;     // result item loaded into output register
    logic rd_en;    // fetch label bytes for the next pair
  } dqe_cmd_t;

  typedef struct packed {
    logic burst_req;  // presented input item causes result items
    logic last;       // pair in flight is the last of its burst
  } dqe_sts_t;

endpackage

### rtl/core/dns_query_encoder.sv
// ----------------------------------------------------------------------------
// dns query encoder
// builds a dns query message from a dotted name streamed one character an item
// input channel (in_valid_i / in_stall_o): action start carries query_id_i,
// action char carries character_i (a dot closes a label), action end closes
// output channel (out_valid_o / out_stall_i): up to two message bytes an item,
// run_last_o on the last item of an input, message_done_o with status_o and
// message_length_o on the closing item; on an error status the consumer drops
// the message; config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) only while idle
// an item causing results holds in_stall_o until its last result is loaded;
// the label buffer read starts at the accepting edge, the first result item is
// loaded once the controller is in emit state, then one a cycle unless stalled
// (header: 6 items, label of length L: (L+2)/2 items, end: up to 35)
// the next input is taken while the final item still sits in the output register
// out_stall_i freezes the burst and the output register; nothing is dropped
// reset: query_type 1, size_limit 300, no message open; label buffer is not
// cleared, only entries written in the current label are read
// ----------------------------------------------------------------------------
`include "dns_query_encoder_assert.svh"

module dns_query_encoder #(
  parameter int unsigned LABEL_MAX = dqe_pkg::LABEL_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [dqe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dqe_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     action_i,
  input  logic [15:0]                    query_id_i,
  input  logic [7:0]                     character_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     first_byte_o,
  output logic [7:0]                     second_byte_o,
  output logic [1:0]                     byte_count_o,
  output logic                           run_last_o,
  output logic                           message_done_o,
  output logic [1:0]                     status_o,
  output logic [9:0]                     message_length_o
);

  // command and status between controller and datapath
  dqe_pkg::dqe_cmd_t cmd;
  dqe_pkg::dqe_sts_t sts;

  // controller: accepts items, sequences byte pair bursts, owns output valid
  dqe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: message state, error checks, label buffer and output fields
  dqe_dp #(
    .LABEL_MAX (LABEL_MAX)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .action_i         (action_i),
    .query_id_i       (query_id_i),
    .character_i      (character_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .first_byte_o     (first_byte_o),
    .second_byte_o    (second_byte_o),
    .byte_count_o     (byte_count_o),
    .run_last_o       (run_last_o),
    .message_done_o   (message_done_o),
    .status_o         (status_o),
    .message_length_o (message_length_o)
  );

  // an item that causes results blocks the input until its burst is loaded
  `DQE_ASSERT_NXT(a_burst_blocks_input, cmd.accept && sts.burst_req, in_stall_o)

  // the closing item always ends its burst
  `DQE_ASSERT_IMP(a_done_is_last, out_valid_o && message_done_o, run_last_o)

  // a length is reported only on a successful close
  `DQE_ASSERT_IMP(a_length_on_ok_close, out_valid_o && (message_length_o != 10'd0),
                  message_done_o && (status_o == dqe_pkg::ERR_OK))

  // an item without bytes is only the closing item of a failed message
  `DQE_ASSERT_IMP(a_empty_item_is_error, out_valid_o && (byte_count_o == 2'd0),
                  message_done_o && (status_o != dqe_pkg::ERR_OK))

endmodule

### rtl/core/dqe_ram.sv
// ----------------------------------------------------------------------------
// dqe_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module dqe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr0_i,
  input  logic [AW-1:0]    raddr1_i,
  output logic [WIDTH-1:0] rdata0_o,
  output logic [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata0_q;
  logic [WIDTH-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

### rtl/core/dqe_ctrl.sv
// ----------------------------------------------------------------------------
// dqe_ctrl
// controller: input acceptance, burst sequencing, output valid
// ----------------------------------------------------------------------------
module dqe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  dqe_pkg::dqe_sts_t sts_i,
  output dqe_pkg::dqe_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } dqe_state_e;

  dqe_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.accept = in_valid_i && (state_q == ST_IDLE);
    cmd_o.load   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
    cmd_o.rd_en  = (cmd_o.accept && sts_i.burst_req) || (cmd_o.load && !sts_i.last);
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept && sts_i.burst_req) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd_o.load && sts_i.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### rtl/core/dqe_dp.sv
// ----------------------------------------------------------------------------
// dqe_dp
// datapath: message state, label buffer, byte pair formatting, output register
// ----------------------------------------------------------------------------
module dqe_dp #(
  parameter int unsigned LABEL_MAX = dqe_pkg::LABEL_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dqe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dqe_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [1:0]                     action_i,
  input  logic [15:0]                    query_id_i,
  input  logic [7:0]                     character_i,
  input  dqe_pkg::dqe_cmd_t              cmd_i,
  output dqe_pkg::dqe_sts_t              sts_o,
  output logic [7:0]                     first_byte_o,
  output logic [7:0]                     second_byte_o,
  output logic [1:0]                     byte_count_o,
  output logic                           run_last_o,
  output logic                           message_done_o,
  output logic [1:0]                     status_o,
  output logic [9:0]                     message_length_o
);

  localparam int unsigned LEN_W = $clog2(LABEL_MAX + 1);
  localparam int unsigned AW    = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  localparam int unsigned PW    = $clog2(LABEL_MAX + 8);

  typedef enum logic [1:0] {
    BK_HEADER,
    BK_LABEL,
    BK_TAIL,
    BK_ERR
  } dqe_burst_e;

  // configuration
  logic [15:0] qtype_q;
  logic [9:0]  slimit_q;

  // message state
  logic [LEN_W-1:0] len_q, len_d;
  logic [9:0]       bw_q, bw_d;
  logic [1:0]       err_q, err_d;
  logic             in_msg_q, in_msg_d;
  logic [15:0]      id_q, id_d;

  // burst in flight
  dqe_burst_e       kind_q, kind_d;
  logic [PW-1:0]    n_q, n_d;
  logic [PW-1:0]    lpart_q, lpart_d;
  logic [PW-1:0]    k_q, k_d;

  // decode helpers
  logic [9:0]       lim;
  logic [PW-1:0]    lab_sz;
  logic [PW-1:0]    tail_lpart;
  logic [10:0]      dot_sum;
  logic [10:0]      total;
  logic [10:0]      tail_sum;
  logic [1:0]       end_err;
  logic             is_dot;
  logic             ram_we;
  logic             burst_req;

  // label buffer access
  logic [PW-1:0]    k_rd;
  logic [PW-1:0]    k_rd_m1;
  logic [7:0]       rdata0;
  logic [7:0]       rdata1;

  // pair formatting
  logic [PW:0]      k_p1;
  logic [PW:0]      k_p2;
  logic             v0, v1, last, closing;
  logic [7:0]       b0, b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qtype_q  <= dqe_pkg::QUERY_TYPE_RST;
      slimit_q <= dqe_pkg::SIZE_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dqe_pkg::REG_QUERY_TYPE: qtype_q  <= cfg_wdata_i;
        dqe_pkg::REG_SIZE_LIMIT: slimit_q <= cfg_wdata_i[9:0];
      endcase
    end
  end

  // limit in force is the smaller of the register and the build maximum
  assign lim = ({1'b0, slimit_q} > 11'(dqe_pkg::LENGTH_MAX)) ?
               10'(dqe_pkg::LENGTH_MAX) : slimit_q;

  assign is_dot     = (character_i == dqe_pkg::DOT_CHAR);
  assign lab_sz     = PW'(len_q) + PW'(1);
  assign tail_lpart = (len_q != '0) ? lab_sz : '0;
  assign dot_sum    = 11'(bw_q) + 11'(lab_sz);
  assign total      = 11'(bw_q) + 11'(tail_lpart);
  assign tail_sum   = total + 11'(dqe_pkg::TAIL_LEN);
  // a label that overruns also overruns with the tail added
  assign end_err    = (err_q != dqe_pkg::ERR_OK) ? err_q :
                      (tail_sum > {1'b0, lim}) ? dqe_pkg::ERR_SIZE : dqe_pkg::ERR_OK;

  always_comb begin
    len_d     = len_q;
    bw_d      = bw_q;
    err_d     = err_q;
    in_msg_d  = in_msg_q;
    id_d      = id_q;
    kind_d    = kind_q;
    n_d       = n_q;
    lpart_d   = lpart_q;
    burst_req = 1'b0;
    ram_we    = 1'b0;
    unique case (action_i)
      dqe_pkg::ACT_START: begin
        in_msg_d = 1'b1;
        len_d    = '0;
        id_d     = query_id_i;
        if (lim < 10'(dqe_pkg::HDR_LEN)) begin
          err_d = dqe_pkg::ERR_SIZE;
          bw_d  = '0;
        end else begin
          err_d     = dqe_pkg::ERR_OK;
          bw_d      = 10'(dqe_pkg::HDR_LEN);
          burst_req = 1'b1;
          kind_d    = BK_HEADER;
          n_d       = PW'(dqe_pkg::HDR_LEN);
          lpart_d   = '0;
        end
      end
      dqe_pkg::ACT_CHAR: begin
        if (in_msg_q && (err_q == dqe_pkg::ERR_OK)) begin
          if (!is_dot) begin
            if (len_q >= LEN_W'(LABEL_MAX)) begin
              err_d = dqe_pkg::ERR_LONG;
            end else begin
              ram_we = 1'b1;
              len_d  = len_q + LEN_W'(1);
            end
          end else if (len_q == '0) begin
            err_d = dqe_pkg::ERR_EMPTY;
          end else if (dot_sum > {1'b0, lim}) begin
            err_d = dqe_pkg::ERR_SIZE;
          end else begin
            burst_req = 1'b1;
            kind_d    = BK_LABEL;
            n_d       = lab_sz;
            lpart_d   = lab_sz;
            bw_d      = dot_sum[9:0];
            len_d     = '0;
          end
        end
      end
      dqe_pkg::ACT_END: begin
        if (in_msg_q) begin
          in_msg_d  = 1'b0;
          len_d     = '0;
          burst_req = 1'b1;
          if (end_err != dqe_pkg::ERR_OK) begin
            err_d   = end_err;
            kind_d  = BK_ERR;
            n_d     = '0;
            lpart_d = '0;
          end else begin
            kind_d  = BK_TAIL;
            lpart_d = tail_lpart;
            n_d     = tail_lpart + PW'(dqe_pkg::TAIL_LEN);
            bw_d    = tail_sum[9:0];
          end
        end
      end
      default: ;
    endcase
  end

  assign sts_o.burst_req = burst_req;

  // pair counter restarts at each burst
  always_comb begin
    k_d = k_q;
    if (cmd_i.accept) begin
      k_d = '0;
    end else if (cmd_i.load) begin
      k_d = k_q + PW'(2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      bw_q     <= '0;
      err_q    <= dqe_pkg::ERR_OK;
      in_msg_q <= 1'b0;
      kind_q   <= BK_HEADER;
      n_q      <= '0;
      lpart_q  <= '0;
      k_q      <= '0;
    end else begin
      if (cmd_i.accept) begin
        len_q    <= len_d;
        bw_q     <= bw_d;
        err_q    <= err_d;
        in_msg_q <= in_msg_d;
        kind_q   <= kind_d;
        n_q      <= n_d;
        lpart_q  <= lpart_d;
      end
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) id_q <= id_d;
  end

  // byte at position p of the burst sits at label address p-1
  assign k_rd    = cmd_i.accept ? '0 : (k_q + PW'(2));
  assign k_rd_m1 = k_rd - PW'(1);

  dqe_ram #(
    .WIDTH (8),
    .DEPTH (LABEL_MAX)
  ) u_label_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we && cmd_i.accept),
    .waddr_i  (len_q[AW-1:0]),
    .wdata_i  (character_i),
    .re_i     (cmd_i.rd_en),
    .raddr0_i (k_rd_m1[AW-1:0]),
    .raddr1_i (k_rd[AW-1:0]),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  function automatic logic [7:0] burst_byte(
    input dqe_burst_e    kind,
    input logic [PW-1:0] pos,
    input logic [PW-1:0] lpart,
    input logic [15:0]   id,
    input logic [15:0]   qtype,
    input logic [7:0]    mem_b
  );
    logic [PW-1:0] t;
    logic [7:0]    b;
    t = pos - lpart;
    b = 8'h00;
    case (kind)
      BK_HEADER: begin
        case (pos)
          PW'(dqe_pkg::POS_ID_HI):   b = id[15:8];
          PW'(dqe_pkg::POS_ID_LO):   b = id[7:0];
          PW'(dqe_pkg::POS_FLAGS):   b = dqe_pkg::FLAGS_RD;
          PW'(dqe_pkg::POS_QDCOUNT): b = dqe_pkg::QDCOUNT_LO;
          default:                   b = 8'h00;
        endcase
      end
      BK_LABEL, BK_TAIL: begin
        if (pos < lpart) begin
          // length prefix, then buffered label bytes
          b = (pos == '0) ? 8'(lpart - PW'(1)) : mem_b;
        end else begin
          case (t)
            PW'(dqe_pkg::TPOS_TYPE_HI): b = qtype[15:8];
            PW'(dqe_pkg::TPOS_TYPE_LO): b = qtype[7:0];
            PW'(dqe_pkg::TPOS_CLASS):   b = dqe_pkg::CLASS_IN_LO;
            default:                    b = 8'h00;
          endcase
        end
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  assign k_p1    = {1'b0, k_q} + (PW+1)'(1);
  assign k_p2    = {1'b0, k_q} + (PW+1)'(2);
  assign v0      = (k_q < n_q);
  assign v1      = (k_p1 < {1'b0, n_q});
  assign last    = (k_p2 >= {1'b0, n_q});
  assign closing = last && ((kind_q == BK_TAIL) || (kind_q == BK_ERR));
  assign b0      = burst_byte(kind_q, k_q, lpart_q, id_q, qtype_q, rdata0);
  assign b1      = burst_byte(kind_q, k_p1[PW-1:0], lpart_q, id_q, qtype_q, rdata1);

  assign sts_o.last = last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      first_byte_o     <= v0 ? b0 : 8'h00;
      second_byte_o    <= v1 ? b1 : 8'h00;
      byte_count_o     <= v1 ? 2'd2 : (v0 ? 2'd1 : 2'd0);
      run_last_o       <= last;
      message_done_o   <= closing;
      status_o         <= closing ? err_q : dqe_pkg::ERR_OK;
      message_length_o <= (closing && (kind_q == BK_TAIL)) ? bw_q : 10'd0;
    end
  end

endmodule

### tb/tb_dns_query_encoder.sv
// ----------------------------------------------------------------------------
// tb_dns_query_encoder
// self-checking bench for the dns query encoder
// a queue of host items (start, name characters, end) feeds a clocked driver
// with random gaps; a clocked monitor stalls the result side at random and
// checks each result item against a predictor of the label buffer, the byte
// count and the sticky error; a short directed sequence under reset
// configuration comes first, then random messages over several register settings
// ----------------------------------------------------------------------------
module tb_dns_query_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  // action code the block leaves unused, must be ignored
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // one host item as presented on the input channel
  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] query_id;
    logic [7:0]  character;
  } host_item_t;

  // one result item, field order matches the output ports
  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [1:0] byte_count;
    logic       run_last;
    logic       message_done;
    logic [1:0] status;
    logic [9:0] message_length;
  } byte_pair_t;

  // clock and reset
  logic clk_i;
  logic rst_ni = 1'b0;

  // block inputs, all known from time zero
  logic                           cfg_we_i    = 1'b0;
  logic [dqe_pkg::CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [dqe_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                           in_valid_i  = 1'b0;
  logic [1:0]                     action_i    = dqe_pkg::ACT_START;
  logic [15:0]                    query_id_i  = '0;
  logic [7:0]                     character_i = '0;
  logic                           out_stall_i = 1'b0;

  // block outputs
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] first_byte_o;
  logic [7:0] second_byte_o;
  logic [1:0] byte_count_o;
  logic       run_last_o;
  logic       message_done_o;
  logic [1:0] status_o;
  logic [9:0] message_length_o;

  dns_query_encoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .query_id_i       (query_id_i),
    .character_i      (character_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .first_byte_o     (first_byte_o),
    .second_byte_o    (second_byte_o),
    .byte_count_o     (byte_count_o),
    .run_last_o       (run_last_o),
    .message_done_o   (message_done_o),
    .status_o         (status_o),
    .message_length_o (message_length_o)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // bench state
  // ---------------------------------------------------------------------------
  host_item_t  host_items[$];      // items waiting to be driven, front is on the bus
  byte_pair_t  expected_pairs[$];  // predicted result items, oldest first
  int          queued_count   = 0; // items queued so far, steers phase length
  int          mismatch_count = 0;
  bit          idle_on        = 1'b1; // random gaps and stalls enabled
  int unsigned send_gap       = 0;    // idle cycles left before the next item
  int unsigned stall_left     = 0;    // stall cycles left on the result side

  // predictor copy of the registers and of the encoder state
  logic [15:0] type_reg = dqe_pkg::QUERY_TYPE_RST;
  logic [9:0]  size_reg = dqe_pkg::SIZE_LIMIT_RST;
  logic [7:0]  label_buf[64];
  int          label_len = 0;
  int          msg_bytes = 0;
  logic [1:0]  err_code  = dqe_pkg::ERR_OK;
  bit          msg_open  = 1'b0;
  logic [7:0]  msg_chunk[$];       // bytes one input item sends, in order

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // length prefix then buffered label bytes
  function automatic void add_label();
    msg_chunk.push_back(label_len[7:0]);
    for (int i = 0; i < label_len; i++) msg_chunk.push_back(label_buf[i]);
  endfunction

  // pack msg_chunk two bytes per item; a close with no bytes still gives one item
  function automatic void split_into_pairs(input bit closing, input logic [1:0] st,
                                           input logic [9:0] len);
    int         n_items;
    byte_pair_t pair;
    n_items = (msg_chunk.size() + 1) / 2;
    if (n_items == 0 && closing) n_items = 1;
    for (int k = 0; k < n_items; k++) begin
      pair = '0;
      if (2 * k < msg_chunk.size()) begin
        pair.first_byte = msg_chunk[2 * k];
        pair.byte_count = 2'd1;
      end
      if (2 * k + 1 < msg_chunk.size()) begin
        pair.second_byte = msg_chunk[2 * k + 1];
        pair.byte_count  = 2'd2;
      end
      pair.run_last = (k == n_items - 1);
      if (pair.run_last && closing) begin
        pair.message_done   = 1'b1;
        pair.status         = st;
        pair.message_length = len;
      end
      expected_pairs.push_back(pair);
    end
  endfunction

  // expected result items of one accepted host item
  function automatic void encode_item(input host_item_t it);
    int lim;
    int total;
    msg_chunk.delete();
    lim = (size_reg > dqe_pkg::LENGTH_MAX) ? dqe_pkg::LENGTH_MAX : size_reg;
    case (it.action)
      dqe_pkg::ACT_START: begin
        // a start always reopens, abandoning any message in progress
        msg_open  = 1'b1;
        label_len = 0;
        msg_bytes = 0;
        err_code  = dqe_pkg::ERR_OK;
        if (lim < dqe_pkg::HDR_LEN) begin
          err_code = dqe_pkg::ERR_SIZE;
        end else begin
          msg_chunk = '{it.query_id[15:8], it.query_id[7:0], dqe_pkg::FLAGS_RD, 8'h00,
                        8'h00, dqe_pkg::QDCOUNT_LO, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'h00};
          msg_bytes = dqe_pkg::HDR_LEN;
          split_into_pairs(1'b0, dqe_pkg::ERR_OK, '0);
        end
      end
      dqe_pkg::ACT_CHAR: begin
        if (msg_open && err_code == dqe_pkg::ERR_OK) begin
          if (it.character != dqe_pkg::DOT_CHAR) begin
            if (label_len >= dqe_pkg::LABEL_MAX_DEF) begin
              err_code = dqe_pkg::ERR_LONG;
            end else begin
              label_buf[label_len] = it.character;
              label_len++;
            end
          end else if (label_len == 0) begin
            err_code = dqe_pkg::ERR_EMPTY;
          end else if (msg_bytes + 1 + label_len > lim) begin
            err_code = dqe_pkg::ERR_SIZE;
          end else begin
            add_label();
            msg_bytes += msg_chunk.size();
            label_len = 0;
            split_into_pairs(1'b0, dqe_pkg::ERR_OK, '0);
          end
        end
      end
      dqe_pkg::ACT_END: begin
        if (msg_open) begin
          msg_open = 1'b0;
          // every size check comes before any byte of the tail
          if (err_code == dqe_pkg::ERR_OK) begin
            total = msg_bytes;
            if (label_len > 0) begin
              total += 1 + label_len;
              if (total > lim) err_code = dqe_pkg::ERR_SIZE;
            end
            if (err_code == dqe_pkg::ERR_OK && total + dqe_pkg::TAIL_LEN > lim)
              err_code = dqe_pkg::ERR_SIZE;
          end
          if (err_code != dqe_pkg::ERR_OK) begin
            label_len = 0;
            split_into_pairs(1'b1, err_code, '0);
          end else begin
            if (label_len > 0) add_label();
            msg_chunk.push_back(8'h00);
            msg_chunk.push_back(type_reg[15:8]);
            msg_chunk.push_back(type_reg[7:0]);
            msg_chunk.push_back(8'h00);
            msg_chunk.push_back(dqe_pkg::CLASS_IN_LO);
            msg_bytes = (msg_bytes + msg_chunk.size()) & 'h3ff;
            label_len = 0;
            split_into_pairs(1'b1, dqe_pkg::ERR_OK, msg_bytes[9:0]);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents the queue front, holds it while stalled
  // ---------------------------------------------------------------------------

  // gap or stall length: mostly short, a few long
  function automatic int unsigned pick_gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        encode_item(host_items.pop_front());
        send_gap = (idle_on && $urandom_range(99) >= 55) ? pick_gap_len() : 0;
      end
      if (in_valid_i && in_stall_o) begin
        // stalled item stays on the bus unchanged
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (host_items.size() > 0) begin
        in_valid_i  <= 1'b1;
        action_i    <= host_items[0].action;
        query_id_i  <= host_items[0].query_id;
        character_i <= host_items[0].character;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random stall on the result side, checks every accepted item
  // ---------------------------------------------------------------------------

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
      mismatch_count++;
    end
  endfunction

  function automatic void check_pair();
    byte_pair_t seen;
    byte_pair_t want;
    seen = {first_byte_o, second_byte_o, byte_count_o, run_last_o, message_done_o,
            status_o, message_length_o};
    if (expected_pairs.size() == 0) begin
      $display("%0t: unexpected result item, expected none, got %h", $time, seen);
      mismatch_count++;
      return;
    end
    want = expected_pairs.pop_front();
    compare_field("first_byte", 16'(want.first_byte), 16'(seen.first_byte));
    compare_field("second_byte", 16'(want.second_byte), 16'(seen.second_byte));
    compare_field("byte_count", 16'(want.byte_count), 16'(seen.byte_count));
    compare_field("run_last", 16'(want.run_last), 16'(seen.run_last));
    compare_field("message_done", 16'(want.message_done), 16'(seen.message_done));
    compare_field("status", 16'(want.status), 16'(seen.status));
    compare_field("message_length", 16'(want.message_length),
                  16'(seen.message_length));
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_pair();
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (idle_on && $urandom_range(5) == 0) stall_left = pick_gap_len();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic void push_item(input logic [1:0] act, input logic [15:0] id,
                                    input logic [7:0] ch);
    host_items.push_back('{action: act, query_id: id, character: ch});
    queued_count++;
  endfunction

  // any byte but the separator
  function automatic logic [7:0] name_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == dqe_pkg::DOT_CHAR);
    return c;
  endfunction

  // one message: start, a few labels, mostly an end; forced_len >= 0 gives
  // a single label of that length
  function automatic void queue_message(input int forced_len);
    int n_labels;
    int len;
    int pick;
    push_item(dqe_pkg::ACT_START, 16'($urandom_range(65535)), 8'($urandom_range(255)));
    n_labels = (forced_len >= 0) ? 1 : $urandom_range(0, 4);
    for (int l = 0; l < n_labels; l++) begin
      pick = $urandom_range(99);
      if (forced_len >= 0) len = forced_len;
      else if (pick < 4) len = 0;                                            // empty label
      else if (pick < 6) len = dqe_pkg::LABEL_MAX_DEF;                       // longest legal
      else if (pick < 8) len = dqe_pkg::LABEL_MAX_DEF + $urandom_range(1, 3); // too long
      else len = $urandom_range(1, 8);
      repeat (len) push_item(dqe_pkg::ACT_CHAR, 16'($urandom_range(65535)), name_char());
      // dot between labels, sometimes a trailing dot
      if (l < n_labels - 1 || $urandom_range(3) == 0)
        push_item(dqe_pkg::ACT_CHAR, 16'($urandom_range(65535)), dqe_pkg::DOT_CHAR);
      // stray item of any kind inside the message
      if ($urandom_range(15) == 0)
        push_item(2'($urandom_range(3)), 16'($urandom_range(65535)),
                  8'($urandom_range(255)));
    end
    // an end is left out now and then, so the next start abandons the message
    if ($urandom_range(9) != 0)
      push_item(dqe_pkg::ACT_END, 16'($urandom_range(65535)), 8'($urandom_range(255)));
    // noise between messages, mostly ignored while idle
    if ($urandom_range(7) == 0)
      push_item(2'($urandom_range(3)), 16'($urandom_range(65535)),
                8'($urandom_range(255)));
  endfunction

  function automatic void queue_messages(input int target);
    int first;
    first = queued_count;
    while (queued_count - first < target) queue_message(-1);
  endfunction

  // wait for all items taken and all results seen, then let the block settle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (host_items.size() != 0 || expected_pairs.size() != 0 || in_valid_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [dqe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == dqe_pkg::REG_QUERY_TYPE) type_reg = val;
    else size_reg = val[9:0];
  endtask

  task automatic run_phase(input logic [15:0] qt, input logic [15:0] lim, input bit idle,
                           input int target, input bit with_long);
    write_reg(dqe_pkg::REG_QUERY_TYPE, qt);
    write_reg(dqe_pkg::REG_SIZE_LIMIT, lim);
    idle_on = idle;
    // longest legal label, then one byte over
    if (with_long) begin
      queue_message(dqe_pkg::LABEL_MAX_DEF);
      queue_message(dqe_pkg::LABEL_MAX_DEF + 1);
    end
    queue_messages(target);
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, under reset configuration
    push_item(dqe_pkg::ACT_CHAR, 16'h0000, "x");          // character while idle
    push_item(dqe_pkg::ACT_END, 16'h0000, 8'h00);         // end while idle
    push_item(ACT_UNUSED, 16'hffff, 8'hff);               // unused action while idle
    push_item(dqe_pkg::ACT_START, 16'hffff, 8'h00);
    push_item(dqe_pkg::ACT_CHAR, 16'h0000, 8'h00);        // zero byte is a plain character
    push_item(dqe_pkg::ACT_CHAR, 16'hffff, 8'hff);
    push_item(dqe_pkg::ACT_CHAR, 16'h0000, 8'h01);
    push_item(dqe_pkg::ACT_CHAR, 16'h0000, dqe_pkg::DOT_CHAR);
    push_item(dqe_pkg::ACT_CHAR, 16'h0000, "c");
    push_item(dqe_pkg::ACT_END, 16'h0000, 8'h00);         // label still pending at end
    push_item(dqe_pkg::ACT_START, 16'h0000, 8'hff);
    push_item(dqe_pkg::ACT_CHAR, 16'h0000, dqe_pkg::DOT_CHAR); // empty label
    push_item(dqe_pkg::ACT_CHAR, 16'h0000, "q");          // dropped, error is sticky
    push_item(dqe_pkg::ACT_END, 16'h0000, 8'h00);         // closing item with error status
    push_item(dqe_pkg::ACT_START, 16'h1234, 8'h00);
    push_item(dqe_pkg::ACT_END, 16'h0000, 8'h00);         // empty name
    push_item(dqe_pkg::ACT_START, 16'ha5a5, 8'h00);
    push_item(dqe_pkg::ACT_CHAR, 16'h0000, "a");
    push_item(dqe_pkg::ACT_CHAR, 16'h0000, dqe_pkg::DOT_CHAR);
    push_item(dqe_pkg::ACT_END, 16'h0000, 8'h00);         // trailing dot
    push_item(dqe_pkg::ACT_START, 16'h5a5a, 8'h00);
    push_item(dqe_pkg::ACT_CHAR, 16'h0000, "k");
    push_item(dqe_pkg::ACT_START, 16'h0f0f, 8'h00);       // restart inside a message
    push_item(ACT_UNUSED, 16'h0000, 8'h00);               // unused action inside a message
    push_item(dqe_pkg::ACT_END, 16'h0000, 8'h00);
    queue_messages(30);
    wait_idle();

    // widest limit, long labels, no idling
    run_phase(16'hffff, 16'd512, 1'b0, 50, 1'b1);
    // header only just fits, every name overflows
    run_phase(16'h0000, 16'd12, 1'b1, 20, 1'b0);
    // room for the empty name only
    run_phase(16'($urandom_range(65535)), 16'd17, 1'b1, 20, 1'b0);
    // header does not fit
    run_phase(16'd28, 16'd11, 1'b1, 10, 1'b0);
    // above the hard maximum, clamped
    run_phase(16'($urandom_range(65535)), 16'd1023, 1'b0, 20, 1'b0);
    // tight limit, frequent overflow
    run_phase(16'($urandom_range(65535)), 16'd60, 1'b1, 20, 1'b0);
    // back to reset values
    run_phase(dqe_pkg::QUERY_TYPE_RST, 16'(dqe_pkg::SIZE_LIMIT_RST), 1'b1, 20, 1'b0);

    if (mismatch_count == 0 && expected_pairs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("%0t: timeout, %0d items pending, %0d results pending", $time,
             host_items.size(), expected_pairs.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
